>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the fragment planner.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UIFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uifp: same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define UIFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uifp: next-cycle implication violated");

`endif

>>> rtl/uifp_pkg.sv
// Package of the UDP/IPv4 fragment planner: sizes, header constants, types
// and the segment size function. No dependencies.
package uifp_pkg;

    localparam int BUFFER_USABLE = 2048;

    localparam int MTU_W      = 14;
    localparam int LEN_W      = 16;
    localparam int OFF_W      = 13;
    localparam int LIM_W      = MTU_W + 1;
    localparam int SEG_W      = $clog2(BUFFER_USABLE + 1);
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W      = $clog2(MAX_RESULTS);

    localparam logic [MTU_W-1:0] MTU_RESET   = MTU_W'(1500);
    localparam logic [MTU_W-1:0] MTU_FLOOR   = MTU_W'(1044);
    localparam logic [LIM_W-1:0] LIMIT_FLOOR = LIM_W'(1058);
    localparam logic [LIM_W-1:0] LIMIT_CEIL  = LIM_W'(BUFFER_USABLE);
    localparam logic [LIM_W-1:0] ETH_HDR     = LIM_W'(14);
    localparam logic [LIM_W-1:0] HDR_ALL     = LIM_W'(42);
    localparam logic [LEN_W-1:0] IP_HDR      = LEN_W'(20);
    localparam logic [LEN_W-1:0] UDP_HDR     = LEN_W'(8);
    localparam logic [LEN_W-1:0] IP_UDP_HDR  = LEN_W'(28);
    localparam logic [LEN_W-1:0] PAYLOAD_LIMIT = LEN_W'((1 << 16) - 28);
    localparam logic [LEN_W-1:0] ID_RESET    = LEN_W'(16'h0432);
    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(MAX_RESULTS - 1);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PLAN = 3'b010,
        S_FRAG = 3'b100
    } state_t;

    // Result payload, lowest field last in the declaration.
    typedef struct packed {
        logic             pad;
        logic [LEN_W-1:0] data_bytes;
        logic [LEN_W-1:0] data_start;
        logic [LEN_W-1:0] ip_id;
        logic             dont_fragment_bit;
        logic             more_fragments;
        logic [OFF_W-1:0] fragment_offset;
        logic [LEN_W-1:0] udp_length;
        logic [LEN_W-1:0] ip_total_length;
    } result_t;

    function automatic logic [SEG_W-1:0] seg_from_mtu(input logic [MTU_W-1:0] mtu);
        logic [MTU_W-1:0] mtu_eff;
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] room;
        mtu_eff = (mtu < MTU_FLOOR) ? MTU_FLOOR : mtu;
        lim     = LIM_W'(mtu_eff) + ETH_HDR;
        if (lim > LIMIT_CEIL)
            lim = LIMIT_CEIL;
        if (lim < LIMIT_FLOOR)
            lim = LIMIT_FLOOR;
        room = (lim - HDR_ALL) & ~LIM_W'(7);
        return room[SEG_W-1:0];
    endfunction

    localparam logic [SEG_W-1:0] SEG_RESET = seg_from_mtu(MTU_RESET);

endpackage

>>> rtl/udp_ipv4_fragment_planner_unit.sv
// Top level of the UDP/IPv4 fragment planner: request in, one header plan
// per IPv4 packet out. Depends on uifp_pkg.
//
// A request is taken while idle and planned in the next cycle, which emits
// either the single unfragmented plan, the error result or the first
// fragment; each further fragment then follows from the fragment state,
// and the result side can stall any of them. One shared subtractor
// compares the payload against the segment size in the planning cycle and
// yields the remaining byte count for each later fragment. s_axis_tready
// is high only between requests. A path_mtu write is taken only while the
// block is idle with no result pending, and recomputes the segment size at once.
module udp_ipv4_fragment_planner_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [uifp_pkg::MTU_W-1:0] cfg_data,        // path_mtu
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] payload_length, [16] dont_fragment, [23:17] zero
    input  logic [23:0]                s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [15:0] ip_total_length, [31:16] udp_length, [44:32] fragment_offset,
    // [45] more_fragments, [46] dont_fragment_bit, [62:47] ip_id,
    // [78:63] data_start, [94:79] data_bytes, [95] zero
    output logic [95:0]                m_axis_tdata,
    output logic                       m_axis_tuser,    // [0] status
    output logic                       m_axis_tlast     // last
);

    localparam int LEN_W = uifp_pkg::LEN_W;
    localparam int OFF_W = uifp_pkg::OFF_W;
    localparam int SEG_W = uifp_pkg::SEG_W;
    localparam int CNT_W = uifp_pkg::CNT_W;

    uifp_pkg::state_t        state_reg, state_next;
    logic [SEG_W-1:0]        seg_reg;
    logic [LEN_W-1:0]        fragment_id_reg, fragment_id_next;
    logic                    out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    df_reg, df_next;
    logic [LEN_W-1:0]        start_reg, start_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        id_cur_reg, id_cur_next;
    uifp_pkg::result_t       out_reg, out_next;
    logic                    status_reg, status_next;
    logic                    last_reg, last_next;

    logic                    in_fire;
    logic                    can_load;
    logic [LEN_W-1:0]        sub_b;
    logic [LEN_W:0]          diff;
    logic                    len_gt_seg;
    logic [LEN_W-1:0]        seg_ext;
    logic [LEN_W-1:0]        seg8;
    logic [LEN_W-1:0]        rem;
    logic [LEN_W-1:0]        take;
    logic                    fin;

    assign cfg_ready     = (state_reg == uifp_pkg::S_IDLE) && !out_valid_reg;
    assign s_axis_tready = (state_reg == uifp_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign can_load      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

    // Shared subtractor: payload minus segment size, or payload minus start.
    assign seg_ext    = LEN_W'(seg_reg);
    assign seg8       = seg_ext + uifp_pkg::UDP_HDR;
    assign sub_b      = (state_reg == uifp_pkg::S_PLAN) ? seg_ext : start_reg;
    assign diff       = {1'b0, len_reg} - {1'b0, sub_b};
    assign len_gt_seg = !diff[LEN_W] && (diff[LEN_W-1:0] != '0);
    assign rem        = diff[LEN_W-1:0];
    assign take       = (rem < seg8) ? rem : seg8;
    assign fin        = (rem <= seg8) || (cnt_reg == uifp_pkg::CNT_LAST);

    always_comb
    begin
        state_next       = state_reg;
        fragment_id_next = fragment_id_reg;
        out_valid_next   = out_valid_reg;
        len_next         = len_reg;
        df_next          = df_reg;
        start_next       = start_reg;
        off_next         = off_reg;
        cnt_next         = cnt_reg;
        id_cur_next      = id_cur_reg;
        out_next         = out_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            uifp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    len_next   = s_axis_tdata[LEN_W-1:0];
                    df_next    = s_axis_tdata[LEN_W];
                    state_next = uifp_pkg::S_PLAN;
                end
            end
            uifp_pkg::S_PLAN:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    status_next    = uifp_pkg::STATUS_OK;
                    last_next      = 1'b1;
                    state_next     = uifp_pkg::S_IDLE;
                    if (!len_gt_seg)
                    begin
                        out_next.ip_total_length   = len_reg + uifp_pkg::IP_UDP_HDR;
                        out_next.udp_length        = len_reg + uifp_pkg::UDP_HDR;
                        out_next.dont_fragment_bit = df_reg;
                        out_next.data_bytes        = len_reg;
                    end
                    else if (df_reg || (len_reg >= uifp_pkg::PAYLOAD_LIMIT))
                    begin
                        status_next = uifp_pkg::STATUS_ERR;
                    end
                    else
                    begin
                        out_next.ip_total_length = seg_ext + uifp_pkg::IP_UDP_HDR;
                        out_next.udp_length      = len_reg + uifp_pkg::UDP_HDR;
                        out_next.more_fragments  = 1'b1;
                        out_next.ip_id           = fragment_id_reg;
                        out_next.data_bytes      = seg_ext;
                        last_next                = 1'b0;
                        id_cur_next              = fragment_id_reg;
                        fragment_id_next         = fragment_id_reg + LEN_W'(1);
                        start_next               = seg_ext;
                        off_next                 = OFF_W'(seg8 >> 3);
                        cnt_next                 = CNT_W'(1);
                        state_next               = uifp_pkg::S_FRAG;
                    end
                end
            end
            uifp_pkg::S_FRAG:
            begin
                if (can_load)
                begin
                    out_valid_next             = 1'b1;
                    status_next                = uifp_pkg::STATUS_OK;
                    last_next                  = fin;
                    out_next.pad               = 1'b0;
                    out_next.ip_total_length   = take + uifp_pkg::IP_HDR;
                    out_next.udp_length        = len_reg + uifp_pkg::UDP_HDR;
                    out_next.fragment_offset   = off_reg;
                    out_next.more_fragments    = !fin;
                    out_next.dont_fragment_bit = 1'b0;
                    out_next.ip_id             = id_cur_reg;
                    out_next.data_start        = start_reg;
                    out_next.data_bytes        = take;
                    start_next                 = start_reg + take;
                    off_next                   = off_reg + OFF_W'(take >> 3);
                    cnt_next                   = cnt_reg + CNT_W'(1);
                    if (fin)
                        state_next = uifp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = uifp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= uifp_pkg::S_IDLE;
            seg_reg         <= uifp_pkg::SEG_RESET;
            fragment_id_reg <= uifp_pkg::ID_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fragment_id_reg <= fragment_id_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
                seg_reg <= uifp_pkg::seg_from_mtu(cfg_data);
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        df_reg     <= df_next;
        start_reg  <= start_next;
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        id_cur_reg <= id_cur_next;
        out_reg    <= out_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

endmodule

>>> rtl/uifp_checker.sv
// Port-level checker of the fragment planner and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module uifp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic        out_stall;
    logic        out_err;
    logic        out_more;
    logic        in_fire;
    logic [97:0] out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_err   = m_axis_tvalid && m_axis_tuser;
    assign out_more  = m_axis_tvalid && !m_axis_tlast;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

    `UIFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    `UIFP_ASSERT_IMPL(a_err_single, clk, rst_n, out_err, m_axis_tlast && (m_axis_tdata == '0))
    `UIFP_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_fire, !s_axis_tready)
    `UIFP_ASSERT_IMPL(a_mf_not_last, clk, rst_n, out_more, m_axis_tdata[45] && !m_axis_tuser)

endmodule

bind udp_ipv4_fragment_planner_unit uifp_checker u_uifp_checker (.*);

>>> tb/udp_ipv4_fragment_planner_unit_tb.sv
// Testbench of the UDP/IPv4 fragment planner: drives send requests and path MTU
// writes, predicts every header plan and checks each result transaction.
// Depends on uifp_pkg and udp_ipv4_fragment_planner_unit.
`timescale 1ns / 1ps

module udp_ipv4_fragment_planner_unit_tb;

    localparam int unsigned MTU_POWER_ON = 1500;
    localparam int unsigned MTU_MIN      = 1044;
    localparam int unsigned MTU_MAX      = 9216;
    localparam int unsigned LIMIT_MIN    = 1058;
    localparam int unsigned ETH_BYTES    = 14;
    localparam int unsigned HEADER_BYTES = 42;
    localparam int unsigned IP_BYTES     = 20;
    localparam int unsigned UDP_BYTES    = 8;
    localparam int unsigned PAYLOAD_MAX  = 65508;
    localparam bit [15:0]   ID_START     = 16'h0432;
    localparam int          PHASE_ITEMS  = 42;

    typedef struct {
        bit        status;
        bit [15:0] ip_total_length;
        bit [15:0] udp_length;
        bit [12:0] fragment_offset;
        bit        more_fragments;
        bit        dont_fragment_bit;
        bit [15:0] ip_id;
        bit [15:0] data_start;
        bit [15:0] data_bytes;
        bit        last;
    } packet_plan_t;

    class fragment_plan_scoreboard;
        int unsigned  path_mtu;
        bit [15:0]    fragment_id;
        packet_plan_t pending_plans[$];
        int unsigned  errors;

        function new();
            path_mtu    = MTU_POWER_ON;
            fragment_id = ID_START;
            errors      = 0;
        endfunction

        function int unsigned seg_size();
            int unsigned lim;
            lim = ((path_mtu < MTU_MIN) ? MTU_MIN : path_mtu) + ETH_BYTES;
            if (lim > uifp_pkg::BUFFER_USABLE)
                lim = uifp_pkg::BUFFER_USABLE;
            if (lim < LIMIT_MIN)
                lim = LIMIT_MIN;
            return (lim - HEADER_BYTES) & ~32'd7;
        endfunction

        function void add_plan(bit status, int unsigned total, int unsigned ulen,
                               int unsigned offset, bit mf, bit df, bit [15:0] id,
                               int unsigned start, int unsigned bytes, bit last);
            packet_plan_t p;
            p.status            = status;
            p.ip_total_length   = total[15:0];
            p.udp_length        = ulen[15:0];
            p.fragment_offset   = offset[12:0];
            p.more_fragments    = mf;
            p.dont_fragment_bit = df;
            p.ip_id             = id;
            p.data_start        = start[15:0];
            p.data_bytes        = bytes[15:0];
            p.last              = last;
            pending_plans.push_back(p);
        endfunction

        function void note_request(bit [15:0] len, bit df);
            int unsigned seg;
            int unsigned ulen;
            int unsigned start;
            int unsigned offset;
            int unsigned take;
            int unsigned n;
            bit          fin;
            bit [15:0]   id;
            seg  = seg_size();
            ulen = len + UDP_BYTES;
            if (len <= seg)
            begin
                add_plan(uifp_pkg::STATUS_OK, len + IP_BYTES + UDP_BYTES, ulen, 0, 1'b0, df,
                         16'd0, 0, len, 1'b1);
                return;
            end
            if (df || len >= PAYLOAD_MAX)
            begin
                add_plan(uifp_pkg::STATUS_ERR, 0, 0, 0, 1'b0, 1'b0, 16'd0, 0, 0, 1'b1);
                return;
            end
            id          = fragment_id;
            fragment_id = fragment_id + 16'd1;
            add_plan(uifp_pkg::STATUS_OK, seg + IP_BYTES + UDP_BYTES, ulen, 0, 1'b1,
                     1'b0, id, 0, seg, 1'b0);
            start  = seg;
            offset = (seg + UDP_BYTES) >> 3;
            n      = 1;
            while (start < len && n < uifp_pkg::MAX_RESULTS)
            begin
                take = (len - start < seg + UDP_BYTES) ? len - start : seg + UDP_BYTES;
                fin  = (start + take >= len) || (n + 1 >= uifp_pkg::MAX_RESULTS);
                add_plan(uifp_pkg::STATUS_OK, take + IP_BYTES, ulen, offset, !fin, 1'b0,
                         id, start, take, fin);
                start  += take;
                offset += take >> 3;
                n++;
            end
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_plan(bit [95:0] data, bit status, bit last);
            packet_plan_t p;
            if (pending_plans.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual data %h", $time,
                         data);
                return;
            end
            p = pending_plans.pop_front();
            compare_field("status", p.status, status);
            compare_field("ip_total_length", p.ip_total_length, data[15:0]);
            compare_field("udp_length", p.udp_length, data[31:16]);
            compare_field("fragment_offset", p.fragment_offset, data[44:32]);
            compare_field("more_fragments", p.more_fragments, data[45]);
            compare_field("dont_fragment_bit", p.dont_fragment_bit, data[46]);
            compare_field("ip_id", p.ip_id, data[62:47]);
            compare_field("data_start", p.data_start, data[78:63]);
            compare_field("data_bytes", p.data_bytes, data[94:79]);
            compare_field("last", p.last, last);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n         = 1'b0;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [uifp_pkg::MTU_W-1:0] cfg_data      = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [23:0]                s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [95:0]                m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       m_axis_tlast;

    bit                      calm    = 1'b0;
    int unsigned             rx_hold = 0;
    fragment_plan_scoreboard plans   = new();

    udp_ipv4_fragment_planner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            plans.check_plan(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (rx_hold > 0)
        begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end

    task automatic send_request(input bit [15:0] len, input bit df);
        if (!calm && $urandom_range(99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, df, len};
        do @(posedge clk); while (!s_axis_tready);
        plans.note_request(len, df);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (plans.pending_plans.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_mtu(input bit [uifp_pkg::MTU_W-1:0] mtu);
        cfg_valid <= 1'b1;
        cfg_data  <= mtu;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        plans.path_mtu = mtu;
    endtask

    function automatic bit [15:0] pick_length(input int unsigned seg);
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom_range(seg, 0));
            4:          return 16'(seg + $urandom_range(16) - 8);
            5, 6, 7:    return 16'($urandom_range(6 * seg, seg + 1));
            8:          return 16'($urandom_range(65535, 6 * seg));
            default:    return 16'($urandom_range(65535, 65500));
        endcase
    endfunction

    task automatic random_phase(input int items);
        int unsigned seg;
        seg = plans.seg_size();
        send_request(16'(PAYLOAD_MAX - 1), 1'b0);
        repeat (items)
            send_request(pick_length(seg), $urandom_range(99) < 20);
    endtask

    task automatic directed_requests();
        int unsigned seg;
        int unsigned lens[$];
        bit          dfs[$];
        seg  = plans.seg_size();
        lens = '{0, 0, 1, seg - 1, seg, seg, seg + 1, seg + 1, seg + 8, seg + 9,
                 2 * seg + 8, 2 * seg + 9, 4096, 16'hAAAA, 16'h5555,
                 PAYLOAD_MAX - 1, PAYLOAD_MAX - 1, PAYLOAD_MAX, 65535, 65535};
        dfs  = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 0,
                 0, 0, 0, 0, 1,
                 0, 1, 0, 0, 1};
        foreach (lens[i])
            send_request(lens[i][15:0], dfs[i]);
    endtask

    initial
    begin
        int unsigned mtus[$];
        mtus = '{MTU_POWER_ON, MTU_MIN, MTU_MAX, 0, 16383, MTU_MIN - 1,
                 uifp_pkg::BUFFER_USABLE - ETH_BYTES, $urandom_range(MTU_MAX, MTU_MIN)};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_requests();
        drain();
        foreach (mtus[i])
        begin
            write_mtu(mtus[i][uifp_pkg::MTU_W-1:0]);
            calm = (i == 2);
            if (i == 4)
                rx_hold <= 400;
            random_phase(PHASE_ITEMS);
            drain();
        end
        calm = 1'b0;
        repeat (20) @(posedge clk);
        if (plans.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
